// File: rtl/blm_pkg.sv
package blm_pkg;

	localparam int SMP_W     = 12;
	localparam int LVL_W     = 12;
	localparam int MV_W      = 14;
	localparam int PCT_W     = 7;
	localparam int SCALE_W   = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = LVL_W + SCALE_W;

	localparam int DVD_W     = 21;
	localparam int DVR_W     = 14;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	localparam int LVL_DVD_W  = LVL_W + 3;
	localparam int LVL_RCP_W  = 16;
	localparam int LVL_SHIFT  = 18;
	localparam int LVL_PROD_W = LVL_DVD_W + LVL_RCP_W;

	localparam logic [MV_W-1:0]      MV_MAX    = '1;
	localparam logic [LVL_RCP_W-1:0] LVL_RECIP = 16'd52429;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_PC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_PC  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TH   = 3'd6;

	localparam logic [SCALE_W-1:0] RST_SCALE    = 16'd6000;
	localparam logic [MV_W-1:0]    RST_EMPTY_MV = 14'd3300;
	localparam logic [MV_W-1:0]    RST_FULL_MV  = 14'd4200;
	localparam logic [PCT_W-1:0]   RST_EMPTY_PC = 7'd0;
	localparam logic [PCT_W-1:0]   RST_FULL_PC  = 7'd100;
	localparam logic [LVL_W-1:0]   RST_LOW_TH   = 12'd2500;
	localparam logic [LVL_W-1:0]   RST_OFF_TH   = 12'd2400;

	typedef struct packed {
		logic    accept;
		logic    div_start;
		logic    avg_load;
		logic    lvl_load;
		logic    mul_load;
		logic    mv_load;
		logic    num_load;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
		logic first;
		logic div_busy;
		logic lim_eq;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/blm_div.sv
module blm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [blm_pkg::DVD_W-1:0]   dividend,
	input  logic [blm_pkg::DVR_W-1:0]   divisor,
	output logic                        busy,
	output logic [blm_pkg::DVD_W-1:0]   quotient
);
	import blm_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVR_W-1:0]     rem_q;
	logic [DVR_W-1:0]     dvr_q;
	logic [DVR_W:0]       trial;
	logic [DVR_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvr_q};
	assign ge    = trial >= {1'b0, dvr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DVD_W);
		end else if (busy_q) begin
			busy_q <= (cnt_q != DIV_CNT_W'(1));
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// File: rtl/blm_dp.sv
module blm_dp #(
	parameter int SAMPLES_PER_BLOCK = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [blm_pkg::CFG_W-1:0]     cfg_data,
	input  logic [blm_pkg::SMP_W-1:0]     sample,
	input  blm_pkg::ctrl_cmd_t            cmd,
	output blm_pkg::dp_stat_t             stat,
	input  logic                          result_ready,
	output logic                          result_valid,
	output logic [blm_pkg::LVL_W-1:0]     smoothed_level,
	output logic [blm_pkg::MV_W-1:0]      millivolts,
	output logic [blm_pkg::PCT_W-1:0]     percent,
	output logic                          low_flag,
	output logic                          off_flag
);
	import blm_pkg::*;

	localparam int CNT_W      = $clog2(SAMPLES_PER_BLOCK + 1);
	localparam int SUM_W      = SMP_W + $clog2(SAMPLES_PER_BLOCK);
	localparam int NUM_W      = MV_W + PCT_W + 2;
	localparam int P_W        = DVD_W + 2;
	localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES_PER_BLOCK);
	localparam int AVG_MUL_W  = SUM_W + 1;
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL =
		AVG_MUL_W'(((1 << AVG_SHIFT) + SAMPLES_PER_BLOCK - 1) / SAMPLES_PER_BLOCK);

	logic [SCALE_W-1:0] scale_q;
	logic [MV_W-1:0]    emv_q;
	logic [MV_W-1:0]    fmv_q;
	logic [PCT_W-1:0]   epc_q;
	logic [PCT_W-1:0]   fpc_q;
	logic [LVL_W-1:0]   low_th_q;
	logic [LVL_W-1:0]   off_th_q;

	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic               first_q;
	logic [LVL_W-1:0]   level_q;
	logic [LVL_W-1:0]   avg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MV_W-1:0]    mv_q;
	logic signed [NUM_W-1:0] num_q;
	logic               result_valid_q;

	logic               last;
	logic               div_start;
	logic               div_busy;
	logic [DVD_W-1:0]   dvd;
	logic [DVR_W-1:0]   dvr;
	logic [DVD_W-1:0]   quo;

	logic [AVG_PROD_W-1:0]   avg_prod;
	logic [LVL_W-1:0]        avg_next;
	logic [LVL_DVD_W-1:0]    lvl_sum;
	logic [LVL_PROD_W-1:0]   lvl_prod;
	logic [LVL_W-1:0]        lvl_next;

	logic signed [MV_W:0]    mv_diff;
	logic signed [PCT_W:0]   pc_diff;
	logic signed [NUM_W-1:0] num_full;
	logic signed [MV_W:0]    den;
	logic [NUM_W-1:0]        num_abs;
	logic [MV_W:0]           den_abs;
	logic                    pct_neg;
	logic [P_W-1:0]          q_mag;
	logic [P_W-1:0]          q_sgn;
	logic [P_W-1:0]          p_raw;
	logic [PCT_W-1:0]        pc_lo;
	logic [PCT_W-1:0]        pc_hi;
	logic [PCT_W-1:0]        pct_div;
	logic [PCT_W-1:0]        pct_eq;
	logic [PCT_W-1:0]        pct_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= RST_SCALE;
			emv_q    <= RST_EMPTY_MV;
			fmv_q    <= RST_FULL_MV;
			epc_q    <= RST_EMPTY_PC;
			fpc_q    <= RST_FULL_PC;
			low_th_q <= RST_LOW_TH;
			off_th_q <= RST_OFF_TH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE:    scale_q  <= cfg_data[SCALE_W-1:0];
				REG_EMPTY_MV: emv_q    <= cfg_data[MV_W-1:0];
				REG_FULL_MV:  fmv_q    <= cfg_data[MV_W-1:0];
				REG_EMPTY_PC: epc_q    <= cfg_data[PCT_W-1:0];
				REG_FULL_PC:  fpc_q    <= cfg_data[PCT_W-1:0];
				REG_LOW_TH:   low_th_q <= cfg_data[LVL_W-1:0];
				REG_OFF_TH:   off_th_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	assign last      = (count_q == CNT_W'(SAMPLES_PER_BLOCK - 1));
	assign div_start = cmd.div_start;

	// floor divide by the block size and by five through constant reciprocals
	assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_MUL);
	assign avg_next = avg_prod[AVG_SHIFT +: LVL_W];
	assign lvl_sum  = LVL_DVD_W'({level_q, 2'b00}) + LVL_DVD_W'(avg_q);
	assign lvl_prod = LVL_PROD_W'(lvl_sum) * LVL_PROD_W'(LVL_RECIP);
	assign lvl_next = lvl_prod[LVL_SHIFT +: LVL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			first_q <= 1'b1;
			level_q <= '0;
		end else begin
			if (cmd.accept) begin
				sum_q   <= sum_q + SUM_W'(sample);
				count_q <= last ? '0 : count_q + CNT_W'(1);
			end else if (cmd.avg_load) begin
				sum_q <= '0;
			end
			if (cmd.avg_load && first_q) begin
				level_q <= avg_next;
				first_q <= 1'b0;
			end else if (cmd.lvl_load) begin
				level_q <= lvl_next;
			end
		end
	end

	assign mv_diff  = $signed({1'b0, mv_q}) - $signed({1'b0, emv_q});
	assign pc_diff  = $signed({1'b0, fpc_q}) - $signed({1'b0, epc_q});
	assign num_full = mv_diff * pc_diff;
	assign den      = $signed({1'b0, fmv_q}) - $signed({1'b0, emv_q});
	assign num_abs  = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign den_abs  = den[MV_W] ? (MV_W+1)'(-den) : (MV_W+1)'(den);
	assign pct_neg  = num_q[NUM_W-1] ^ den[MV_W];

	always_ff @(posedge clk) begin
		if (cmd.avg_load) avg_q <= avg_next;
		if (cmd.mul_load) prod_q <= PROD_W'(level_q) * PROD_W'(scale_q);
		if (cmd.mv_load) begin
			mv_q <= (|prod_q[PROD_W-1:SMP_W+MV_W]) ? MV_MAX : prod_q[SMP_W+MV_W-1:SMP_W];
		end
		if (cmd.num_load) num_q <= num_full;
	end

	assign dvd = num_abs[DVD_W-1:0];
	assign dvr = den_abs[DVR_W-1:0];

	blm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvr),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign pc_lo = (epc_q < fpc_q) ? epc_q : fpc_q;
	assign pc_hi = (epc_q < fpc_q) ? fpc_q : epc_q;
	assign q_mag = P_W'(quo);
	assign q_sgn = pct_neg ? P_W'(-q_mag) : q_mag;
	assign p_raw = q_sgn + P_W'(epc_q);

	always_comb begin
		if ($signed(p_raw) < $signed(P_W'(pc_lo))) begin
			pct_div = pc_lo;
		end else if ($signed(p_raw) > $signed(P_W'(pc_hi))) begin
			pct_div = pc_hi;
		end else begin
			pct_div = p_raw[PCT_W-1:0];
		end
	end

	assign pct_eq   = (mv_q >= fmv_q) ? fpc_q : epc_q;
	assign pct_next = stat.lim_eq ? pct_eq : pct_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			smoothed_level <= level_q;
			millivolts     <= mv_q;
			percent        <= pct_next;
			low_flag       <= level_q < low_th_q;
			off_flag       <= level_q < off_th_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign stat.last     = last;
	assign stat.first    = first_q;
	assign stat.div_busy = div_busy;
	assign stat.lim_eq   = (fmv_q == emv_q);
	assign stat.out_free = !result_valid_q || result_ready;

endmodule

// File: rtl/blm_ctrl.sv
module blm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  blm_pkg::dp_stat_t    stat,
	output blm_pkg::ctrl_cmd_t   cmd
);
	import blm_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_AVG      = 4'd1;
	localparam logic [3:0] ST_LVL      = 4'd2;
	localparam logic [3:0] ST_MUL      = 4'd3;
	localparam logic [3:0] ST_MV       = 4'd4;
	localparam logic [3:0] ST_NUM      = 4'd5;
	localparam logic [3:0] ST_PCT_GO   = 4'd6;
	localparam logic [3:0] ST_PCT_WAIT = 4'd7;
	localparam logic [3:0] ST_FIN      = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = sample_valid;
				if (sample_valid && stat.last) state_d = ST_AVG;
			end
			ST_AVG: begin
				cmd.avg_load = 1'b1;
				state_d      = stat.first ? ST_MUL : ST_LVL;
			end
			ST_LVL: begin
				cmd.lvl_load = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_MV;
			end
			ST_MV: begin
				cmd.mv_load = 1'b1;
				state_d     = ST_NUM;
			end
			ST_NUM: begin
				cmd.num_load = 1'b1;
				state_d      = stat.lim_eq ? ST_FIN : ST_PCT_GO;
			end
			ST_PCT_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_PCT_WAIT;
			end
			ST_PCT_WAIT: begin
				if (!stat.div_busy) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/battery_level_monitor.sv
// channel   | handshake                  | payload
// sample    | sample_valid/sample_ready  | sample[11:0]
// result    | result_valid/result_ready  | smoothed_level, millivolts, percent,
//           |                            | low_flag, off_flag
// config    | cfg_we (no wait)           | cfg_index[2:0], cfg_data[15:0]
//
// One sample is taken per cycle while a block fills.
// The sample completing a block starts block-end work: average, level update, millivolts,
// percent numerator, then start and wait for the 21-step percent divide; the result is
// valid as they end. No level update on the first block; no divide with equal limits.
// Samples are not taken during block-end work; a waiting result holds the final step
// of the next block end, so it stops sampling only then.
// Reset loads the register defaults and clears the block and level state.
module battery_level_monitor #(
	parameter int SAMPLES_PER_BLOCK = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [blm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic [blm_pkg::SMP_W-1:0]     sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [blm_pkg::LVL_W-1:0]     smoothed_level,
	output logic [blm_pkg::MV_W-1:0]      millivolts,
	output logic [blm_pkg::PCT_W-1:0]     percent,
	output logic                          low_flag,
	output logic                          off_flag
);
	import blm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	blm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	blm_dp #(
		.SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.cmd            (cmd),
		.stat           (stat),
		.result_ready   (result_ready),
		.result_valid   (result_valid),
		.smoothed_level (smoothed_level),
		.millivolts     (millivolts),
		.percent        (percent),
		.low_flag       (low_flag),
		.off_flag       (off_flag)
	);

endmodule

// File: rtl/blm_check.sv
module blm_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [blm_pkg::LVL_W-1:0]     smoothed_level,
	input logic [blm_pkg::MV_W-1:0]      millivolts,
	input logic [blm_pkg::PCT_W-1:0]     percent
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result transaction dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(smoothed_level) && $stable(millivolts)
			&& $stable(percent))
		else $error("result payload changed while stalled");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared while samples were being taken");

	a_zero_level_mv: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && smoothed_level == '0 |-> millivolts == '0)
		else $error("nonzero millivolts for zero level");

endmodule

bind battery_level_monitor blm_check u_blm_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_ready   (sample_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.smoothed_level (smoothed_level),
	.millivolts     (millivolts),
	.percent        (percent)
);
